// ===== hdl/stable_sorted_priority_queue_unit_assert.svh =====
// Assertion macros for the sorted priority queue unit.
// No dependencies; included by modules that carry checks.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SSPQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sspq assertion failed");
`define SSPQ_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sspq forbidden condition");
`else
`define SSPQ_ASSERT(lbl, clk, rst_n, prop)
`define SSPQ_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/sspq_pkg.sv =====
// Shared types and constants for the sorted priority queue unit.
// No dependencies.
package sspq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 16;
	localparam int PAYLOAD_BITS  = 32;
	localparam int TYPE_BITS     = 8;
	localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [TYPE_BITS-1:0]     tag;
		logic [PAYLOAD_BITS-1:0]  pay;
	} entry_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_entry;
	} cell_cmd_t;

endpackage

// ===== hdl/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry or shifts from a neighbor. Depends on sspq_pkg.
module sspq_cell (
	input  logic               clk,
	input  sspq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  sspq_pkg::entry_t   left_entry,
	input  logic               left_keep,
	input  sspq_pkg::entry_t   right_entry,
	output sspq_pkg::entry_t   entry,
	output logic               keep
);
	import sspq_pkg::*;

	entry_t entry_q;

	// Equal priority stays ahead of the new item: keeps the order stable.
	assign keep  = occupied && (entry_q.prio >= cmd.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		priority if (cmd.ins) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.new_entry : left_entry;
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/stable_sorted_priority_queue_unit.sv =====
// Top level of the stable sorted priority queue: cell chain, fill count and
// result register. Depends on sspq_pkg, sspq_cell and the assert header.
//
// Every command (insert, remove, clear) is taken when start is high and its
// result appears on the next cycle with done high for exactly that cycle;
// busy never rises, so a new command may follow every cycle. The queue is a
// chain of QUEUE_DEPTH cells ordered by descending priority; all cells
// compare the new priority at once and shift in one step at any depth.
// entry_count and is_empty show the fill after the command. Results cannot be
// held off and must be captured while done is high.
`include "stable_sorted_priority_queue_unit_assert.svh"

module stable_sorted_priority_queue_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic [sspq_pkg::PRIORITY_BITS-1:0] priority_req,
	input  logic [sspq_pkg::TYPE_BITS-1:0]     item_type,
	input  logic [sspq_pkg::PAYLOAD_BITS-1:0]  payload,
	output logic                               done,
	output logic                               ok,
	output logic [sspq_pkg::PRIORITY_BITS-1:0] out_priority,
	output logic [sspq_pkg::TYPE_BITS-1:0]     out_type,
	output logic [sspq_pkg::PAYLOAD_BITS-1:0]  out_payload,
	output logic                               is_empty,
	output logic [sspq_pkg::COUNT_BITS-1:0]    entry_count
);
	import sspq_pkg::*;

	logic [COUNT_BITS-1:0]  count_q;
	logic                   done_q;
	logic                   ok_q;
	entry_t                 head_q;
	cell_cmd_t              cmd;
	entry_t                 cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_keep;
	logic                   full;
	logic                   do_ins;
	logic                   do_rem;
	logic                   do_clr;

	assign busy = 1'b0;

	assign full   = (count_q == COUNT_BITS'(QUEUE_DEPTH));
	assign do_ins = start && (op == OP_INSERT) && (payload != '0) && !full;
	assign do_rem = start && (op == OP_REMOVE) && (count_q != '0);
	assign do_clr = start && (op == OP_CLEAR);

	assign cmd.ins            = do_ins;
	assign cmd.rem            = do_rem;
	assign cmd.new_entry.prio = priority_req;
	assign cmd.new_entry.tag  = item_type;
	assign cmd.new_entry.pay  = payload;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;
		logic   occ;

		if (i == 0) begin : g_head
			assign left_e = cell_entry[0];
			assign left_k = 1'b1;
		end else begin : g_body
			assign left_e = cell_entry[i-1];
			assign left_k = cell_keep[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		assign occ = (COUNT_BITS'(i) < count_q);

		sspq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occ),
			.left_entry  (left_e),
			.left_keep   (left_k),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			done_q <= start;
			ok_q   <= do_ins || do_rem || do_clr;
			priority if (do_clr) begin
				count_q <= '0;
			end else if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Head fields are zero unless the item was a successful remove.
	always_ff @(posedge clk) begin
		head_q <= do_rem ? cell_entry[0] : '0;
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign out_priority = head_q.prio;
	assign out_type     = head_q.tag;
	assign out_payload  = head_q.pay;
	assign entry_count  = count_q;
	assign is_empty     = (count_q == '0);

	`SSPQ_NEVER(a_count_bound, clk, arst_n, count_q > COUNT_BITS'(QUEUE_DEPTH))
	`SSPQ_ASSERT(a_one_result, clk, arst_n, start |=> done)
	`SSPQ_ASSERT(a_zero_pay_rej, clk, arst_n, (start && op == OP_INSERT && payload == '0) |=> !ok)
	`SSPQ_ASSERT(a_rem_count, clk, arst_n, (start && op == OP_REMOVE && count_q != '0) |=> (ok && entry_count == COUNT_BITS'($past(count_q) - 1'b1)))
	`SSPQ_ASSERT(a_full_rej, clk, arst_n, (start && op == OP_INSERT && full) |=> (!ok && entry_count == COUNT_BITS'(QUEUE_DEPTH)))

endmodule
